@@ rtl/xed_pkg.sv @@
// shared types and constant tables for the xml entity decoder
package xed_pkg;

	// entity selector
	localparam logic [1:0] ENT_AMP  = 2'd0;
	localparam logic [1:0] ENT_QUOT = 2'd1;
	localparam logic [1:0] ENT_GT   = 2'd2;
	localparam logic [1:0] ENT_LT   = 2'd3;

	localparam logic [7:0] CH_AMP = 8'h26;

	// one unit of work from classifier to expander: held bytes, then an optional byte
	typedef struct packed {
		logic [1:0] ent;       // entity whose prefix is flushed
		logic [2:0] flush_len; // number of held prefix bytes to emit
		logic       has_data;  // one more byte follows the flushed prefix
		logic [7:0] data;      // that byte
		logic       last;      // request closes the text
	} xed_job_t;

	// queue status toward the expander
	typedef struct packed {
		logic     empty;
		xed_job_t head;
	} xed_q_stat_t;

	// byte at position idx of an entity's text (prefix only, no ';')
	function automatic logic [7:0] ent_byte(input logic [1:0] ent, input logic [2:0] idx);
		logic [7:0] b;
		b = CH_AMP;
		case (ent)
			ENT_AMP: begin
				case (idx)
					3'd1:    b = 8'h61; // a
					3'd2:    b = 8'h6d; // m
					3'd3:    b = 8'h70; // p
					default: b = CH_AMP;
				endcase
			end
			ENT_QUOT: begin
				case (idx)
					3'd1:    b = 8'h71; // q
					3'd2:    b = 8'h75; // u
					3'd3:    b = 8'h6f; // o
					3'd4:    b = 8'h74; // t
					default: b = CH_AMP;
				endcase
			end
			ENT_GT: begin
				case (idx)
					3'd1:    b = 8'h67; // g
					3'd2:    b = 8'h74; // t
					default: b = CH_AMP;
				endcase
			end
			default: begin
				case (idx)
					3'd1:    b = 8'h6c; // l
					3'd2:    b = 8'h74; // t
					default: b = CH_AMP;
				endcase
			end
		endcase
		return b;
	endfunction

endpackage

@@ rtl/xed_front.sv @@
// input side: entity match tracking and classification of each byte into a job
module xed_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,  // [7:0] in_byte
	input  logic             s_tlast,  // in_last
	input  logic             q_full,
	output logic             push,
	output xed_pkg::xed_job_t job
);

	// partial match position, one-hot
	typedef enum logic [12:0] {
		ST_IDLE = 13'b0000000000001,
		ST_HELD = 13'b0000000000010,
		ST_A    = 13'b0000000000100,
		ST_AM   = 13'b0000000001000,
		ST_AMP  = 13'b0000000010000,
		ST_Q    = 13'b0000000100000,
		ST_QU   = 13'b0000001000000,
		ST_QUO  = 13'b0000010000000,
		ST_QUOT = 13'b0000100000000,
		ST_G    = 13'b0001000000000,
		ST_GT   = 13'b0010000000000,
		ST_L    = 13'b0100000000000,
		ST_LT   = 13'b1000000000000
	} xed_state_t;

	xed_state_t state_q;
	xed_state_t nxt;
	xed_state_t ext_state;
	logic       ext;
	logic       done;
	logic [7:0] done_char;
	logic       accept;

	// entity and held length of a match position
	function automatic logic [4:0] st_info(input xed_state_t s);
		logic [4:0] r;
		r = {xed_pkg::ENT_AMP, 3'd0};
		unique case (s)
			ST_HELD: r = {xed_pkg::ENT_AMP, 3'd1};
			ST_A:    r = {xed_pkg::ENT_AMP, 3'd2};
			ST_AM:   r = {xed_pkg::ENT_AMP, 3'd3};
			ST_AMP:  r = {xed_pkg::ENT_AMP, 3'd4};
			ST_Q:    r = {xed_pkg::ENT_QUOT, 3'd2};
			ST_QU:   r = {xed_pkg::ENT_QUOT, 3'd3};
			ST_QUO:  r = {xed_pkg::ENT_QUOT, 3'd4};
			ST_QUOT: r = {xed_pkg::ENT_QUOT, 3'd5};
			ST_G:    r = {xed_pkg::ENT_GT, 3'd2};
			ST_GT:   r = {xed_pkg::ENT_GT, 3'd3};
			ST_L:    r = {xed_pkg::ENT_LT, 3'd2};
			ST_LT:   r = {xed_pkg::ENT_LT, 3'd3};
			default: r = {xed_pkg::ENT_AMP, 3'd0};
		endcase
		return r;
	endfunction

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	// does the byte extend or complete the held prefix
	always_comb begin
		ext       = 1'b0;
		done      = 1'b0;
		done_char = 8'h00;
		ext_state = ST_IDLE;
		unique case (state_q)
			ST_HELD: begin
				ext = 1'b1;
				case (s_tdata)
					8'h61:   ext_state = ST_A;
					8'h71:   ext_state = ST_Q;
					8'h67:   ext_state = ST_G;
					8'h6c:   ext_state = ST_L;
					default: ext = 1'b0;
				endcase
			end
			ST_A: begin
				ext       = (s_tdata == 8'h6d);
				ext_state = ST_AM;
			end
			ST_AM: begin
				ext       = (s_tdata == 8'h70);
				ext_state = ST_AMP;
			end
			ST_AMP: begin
				done      = (s_tdata == 8'h3b);
				done_char = 8'h26;
			end
			ST_Q: begin
				ext       = (s_tdata == 8'h75);
				ext_state = ST_QU;
			end
			ST_QU: begin
				ext       = (s_tdata == 8'h6f);
				ext_state = ST_QUO;
			end
			ST_QUO: begin
				ext       = (s_tdata == 8'h74);
				ext_state = ST_QUOT;
			end
			ST_QUOT: begin
				done      = (s_tdata == 8'h3b);
				done_char = 8'h22;
			end
			ST_G: begin
				ext       = (s_tdata == 8'h74);
				ext_state = ST_GT;
			end
			ST_GT: begin
				done      = (s_tdata == 8'h3b);
				done_char = 8'h3e;
			end
			ST_L: begin
				ext       = (s_tdata == 8'h74);
				ext_state = ST_LT;
			end
			ST_LT: begin
				done      = (s_tdata == 8'h3b);
				done_char = 8'h3c;
			end
			default: begin
				ext  = 1'b0;
				done = 1'b0;
			end
		endcase
	end

	// build the job and the next match position
	always_comb begin
		job      = '0;
		job.last = s_tlast;
		nxt      = state_q;
		if (ext) begin
			if (s_tlast) begin
				{job.ent, job.flush_len} = st_info(ext_state);
				nxt = ST_IDLE;
			end else begin
				nxt = ext_state;
			end
		end else if (done) begin
			job.has_data = 1'b1;
			job.data     = done_char;
			nxt          = ST_IDLE;
		end else begin
			// match broken or idle: flush held bytes, then handle the byte from idle
			{job.ent, job.flush_len} = st_info(state_q);
			job.data     = s_tdata;
			job.has_data = (s_tdata != xed_pkg::CH_AMP) || s_tlast;
			nxt          = ((s_tdata == xed_pkg::CH_AMP) && !s_tlast) ? ST_HELD : ST_IDLE;
		end
	end

	assign push = accept && ((job.flush_len != 3'd0) || job.has_data);

	// match position register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else if (accept) begin
			state_q <= nxt;
		end
	end

endmodule

@@ rtl/xed_queue.sv @@
// short job queue between classifier and expander
module xed_queue #(
	parameter int DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  xed_pkg::xed_job_t     push_job,
	output logic                  full,
	input  logic                  pop,
	output xed_pkg::xed_q_stat_t  stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	xed_pkg::xed_job_t  mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign stat.head  = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && !stat.empty;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/xed_back.sv @@
// output side: expands each job into bytes, one per unstalled cycle, into the output register
module xed_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  xed_pkg::xed_q_stat_t stat,
	output logic                 pop,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [7:0]           m_tdata,  // [7:0] out_byte
	output logic                 m_tlast,  // text_end
	output logic                 m_tuser   // run_last
);

	logic [2:0] idx_q;
	logic [2:0] total;
	logic [7:0] cur_byte;
	logic       final_byte;
	logic       step;
	logic       valid_q;
	logic [7:0] data_q;
	logic       run_last_q;
	logic       text_end_q;

	// byte selection within the current job
	assign total      = stat.head.flush_len + {2'b00, stat.head.has_data};
	assign final_byte = (idx_q == total - 3'd1);
	assign cur_byte   = (idx_q < stat.head.flush_len) ?
		xed_pkg::ent_byte(stat.head.ent, idx_q) : stat.head.data;
	assign step       = !stat.empty && (!valid_q || m_tready);
	assign pop        = step && final_byte;

	// position inside the current job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (step) begin
			idx_q <= final_byte ? 3'd0 : idx_q + 3'd1;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (step) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (step) begin
			data_q     <= cur_byte;
			run_last_q <= final_byte;
			text_end_q <= final_byte && stat.head.last;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tlast  = text_end_q;
	assign m_tuser  = run_last_q;

endmodule

@@ rtl/xml_entity_decoder_unit.sv @@
// top level of the xml entity decoder: classifier, job queue, expander
// an accepted request is written to the job queue, then its first output byte is registered in the output register
// throughput: one input byte per cycle while each byte yields at most one output byte and the output is not stalled
// a byte that breaks a partial match yields up to 6 bytes, one per unstalled cycle from the expander
// the job queue (QUEUE_DEPTH entries) absorbs that burst before s_tready drops
// reset clears the match position, the queue pointers and the output valid
module xml_entity_decoder_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] in_byte
	input  logic       s_tlast,  // in_last
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,  // [7:0] out_byte
	output logic       m_tlast,  // text_end
	output logic       m_tuser   // run_last
);

	logic                 push;
	logic                 q_full;
	logic                 pop;
	xed_pkg::xed_job_t    job;
	xed_pkg::xed_q_stat_t stat;

	// classifier
	xed_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.push     (push),
		.job      (job)
	);

	// job queue
	xed_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (job),
		.full     (q_full),
		.pop      (pop),
		.stat     (stat)
	);

	// expander and output register
	xed_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.stat     (stat),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	// end of text is always the last byte of its run
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> m_tuser)
		else $error("text end without run end");

	// with nothing queued, a taken output byte is not followed by another
	assert property (@(posedge clk) disable iff (!arst_n)
		(stat.empty && m_tready) |=> !m_tvalid)
		else $error("output byte without a queued job");

	// a job never holds more than the longest entity prefix
	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (job.flush_len <= 3'd5))
		else $error("flush length out of range");

endmodule

@@ verif/xml_entity_decoder_unit_tb.sv @@
// testbench for xml_entity_decoder_unit: byte stream stimulus, decode predictor, output check
`timescale 1ns / 1ps

module xml_entity_decoder_unit_tb;

	// match positions of the decoder state
	localparam int MP_IDLE      = 0;
	localparam int MP_HELD_AMP  = 1;
	localparam int MP_AMP_BASE  = 2;
	localparam int MP_QUOT_BASE = 5;
	localparam int MP_GT_BASE   = 9;
	localparam int MP_LT_BASE   = 11;
	localparam int MP_COUNT     = 13;

	localparam int RANDOM_ITEMS = 400;
	localparam int IDLE_LIMIT   = 500;
	localparam int DRAIN_CYCLES = 16;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} text_req_t;

	typedef struct packed {
		logic [7:0] data;
		logic       run_last;
		logic       text_end;
	} decoded_t;

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = 8'h00;
	logic       s_tlast  = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic       m_tlast;
	logic       m_tuser;

	text_req_t  text_q[$];      // requests waiting to be driven
	logic [7:0] text_bytes[$];  // text under construction
	decoded_t   decoded_q[$];   // decoded bytes still to arrive
	logic [7:0] run_bytes[$];   // bytes produced by one request

	int match_pos = MP_IDLE;
	int total_items;
	int directed_items;
	int issued;
	int accepted;
	int checked;
	int errors;
	int burst_left;
	int gap_left;
	int rx_cycle;
	int idle_cycles;

	xml_entity_decoder_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// full text of an entity, '&' through ';'
	function automatic string entity_text(input logic [1:0] ent);
		case (ent)
			xed_pkg::ENT_AMP:  return "&amp;";
			xed_pkg::ENT_QUOT: return "&quot;";
			xed_pkg::ENT_GT:   return "&gt;";
			default:           return "&lt;";
		endcase
	endfunction

	function automatic logic [7:0] entity_glyph(input logic [1:0] ent);
		case (ent)
			xed_pkg::ENT_AMP:  return xed_pkg::CH_AMP;
			xed_pkg::ENT_QUOT: return 8'h22;
			xed_pkg::ENT_GT:   return 8'h3e;
			default:           return 8'h3c;
		endcase
	endfunction

	function automatic int entity_base(input logic [1:0] ent);
		case (ent)
			xed_pkg::ENT_AMP:  return MP_AMP_BASE;
			xed_pkg::ENT_QUOT: return MP_QUOT_BASE;
			xed_pkg::ENT_GT:   return MP_GT_BASE;
			default:           return MP_LT_BASE;
		endcase
	endfunction

	function automatic logic [1:0] entity_of(input int pos);
		if (pos < MP_QUOT_BASE)
			return xed_pkg::ENT_AMP;
		else if (pos < MP_GT_BASE)
			return xed_pkg::ENT_QUOT;
		else if (pos < MP_LT_BASE)
			return xed_pkg::ENT_GT;
		return xed_pkg::ENT_LT;
	endfunction

	// number of bytes held at a match position
	function automatic int held_len(input int pos);
		if (pos == MP_HELD_AMP)
			return 1;
		return pos - entity_base(entity_of(pos)) + 2;
	endfunction

	// emit the held prefix unchanged
	function automatic void release_held(input int pos);
		string t;
		int n;
		logic [7:0] b;
		t = entity_text(entity_of(pos));
		n = held_len(pos);
		for (int i = 0; i < n; i++) begin
			b = t[i];
			run_bytes.push_back(b);
		end
	endfunction

	function automatic void take_from_idle(input logic [7:0] c);
		if (c == xed_pkg::CH_AMP)
			match_pos = MP_HELD_AMP;
		else
			run_bytes.push_back(c);
	endfunction

	// advance the decoder by one request and queue the bytes it yields
	task automatic decode_request(input logic [7:0] c, input logic last);
		int pos;
		int n;
		logic [1:0] ent;
		logic [7:0] b;
		bit found;
		string t;
		run_bytes.delete();
		pos = match_pos;
		if (pos >= MP_COUNT)
			pos = MP_IDLE;
		if (pos == MP_IDLE) begin
			take_from_idle(c);
		end else if (pos == MP_HELD_AMP) begin
			found = 1'b0;
			for (int e = 0; e < 4; e++) begin
				ent = 2'(e);
				t = entity_text(ent);
				b = t[1];
				if (!found && b == c) begin
					match_pos = entity_base(ent);
					found = 1'b1;
				end
			end
			if (!found) begin
				release_held(pos);
				match_pos = MP_IDLE;
				take_from_idle(c);
			end
		end else begin
			ent = entity_of(pos);
			n = held_len(pos);
			t = entity_text(ent);
			b = t[n];
			if (n < t.len() && b == c) begin
				if (n + 1 == t.len()) begin
					run_bytes.push_back(entity_glyph(ent));
					match_pos = MP_IDLE;
				end else begin
					match_pos = pos + 1;
				end
			end else begin
				release_held(pos);
				match_pos = MP_IDLE;
				take_from_idle(c);
			end
		end
		// end of text flushes a partial match
		if (last) begin
			pos = match_pos;
			if (pos >= MP_COUNT)
				pos = MP_IDLE;
			if (pos != MP_IDLE)
				release_held(pos);
			match_pos = MP_IDLE;
		end
		for (int k = 0; k < run_bytes.size(); k++) begin
			decoded_q.push_back({run_bytes[k], k == run_bytes.size() - 1,
				(k == run_bytes.size() - 1) && last});
		end
	endtask

	function automatic void push_string(input string s, input bit end_text);
		logic [7:0] b;
		for (int i = 0; i < s.len(); i++) begin
			b = s[i];
			text_q.push_back({b, end_text && (i == s.len() - 1)});
		end
	endfunction

	// entity characters half the time, else any byte from 01 to ff
	function automatic logic [7:0] random_text_byte();
		string pool;
		logic [7:0] b;
		pool = "&;amplgtquo";
		if ($urandom_range(0, 1) == 0) begin
			b = 8'($urandom_range(1, 255));
		end else begin
			b = pool[$urandom_range(0, pool.len() - 1)];
		end
		return b;
	endfunction

	// one piece of text: full entity, broken prefix, lone '&' or plain byte
	function automatic void add_chunk();
		int kind;
		int n;
		logic [1:0] ent;
		logic [7:0] b;
		string t;
		kind = $urandom_range(0, 15);
		ent = 2'($urandom_range(0, 3));
		t = entity_text(ent);
		if (kind <= 5) begin
			for (int i = 0; i < t.len(); i++) begin
				b = t[i];
				text_bytes.push_back(b);
			end
		end else if (kind <= 8) begin
			n = $urandom_range(1, t.len() - 1);
			for (int i = 0; i < n; i++) begin
				b = t[i];
				text_bytes.push_back(b);
			end
			if ($urandom_range(0, 3) != 0)
				text_bytes.push_back(random_text_byte());
		end else if (kind == 9) begin
			text_bytes.push_back(xed_pkg::CH_AMP);
		end else begin
			text_bytes.push_back(random_text_byte());
		end
	endfunction

	task automatic report_error(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		errors++;
	endtask

	// sender: bursts and gaps, with a drain hold at two points
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 8'h00;
			s_tlast  <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				decode_request(s_tdata, s_tlast);
				accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if ((issued == directed_items || issued == directed_items + 200)
						&& decoded_q.size() != 0) begin
					s_tvalid <= 1'b0;
				end else if (text_q.size() != 0) begin
					{s_tdata, s_tlast} <= text_q.pop_front();
					s_tvalid <= 1'b1;
					issued++;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
							: $urandom_range(1, 16);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: rotates through four stall patterns; check each accepted byte
	always @(posedge clk) begin
		decoded_t exp_byte;
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_cycle <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (decoded_q.size() == 0) begin
					report_error($sformatf("unexpected byte %02h", m_tdata));
				end else begin
					exp_byte = decoded_q.pop_front();
					if (m_tdata !== exp_byte.data)
						report_error($sformatf("byte %0d out_byte %02h, expected %02h",
							checked, m_tdata, exp_byte.data));
					if (m_tuser !== exp_byte.run_last)
						report_error($sformatf("byte %0d run_last %b, expected %b",
							checked, m_tuser, exp_byte.run_last));
					if (m_tlast !== exp_byte.text_end)
						report_error($sformatf("byte %0d text_end %b, expected %b",
							checked, m_tlast, exp_byte.text_end));
				end
				checked++;
			end
			rx_cycle <= rx_cycle + 1;
			case ((rx_cycle / 64) % 4)
				0:       m_tready <= 1'b1;
				1:       m_tready <= 1'($urandom_range(0, 1));
				2:       m_tready <= (rx_cycle % 3 == 0);
				default: m_tready <= (rx_cycle % 5 > 1);
			endcase
		end
	end

	// watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("** xml_entity_decoder_unit: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		int chunks;
		burst_left = 0;
		gap_left = 0;
		issued = 0;
		accepted = 0;
		checked = 0;
		errors = 0;
		idle_cycles = 0;

		// directed: &amp;, &gt; and &lt;, a broken '&quo' prefix, '&' breaking a match,
		// last byte '&', last byte inside a match, byte extremes
		push_string("&amp;&gt;", 1'b0);
		text_q.push_back({8'h01, 1'b0});
		push_string("&lt;&quo", 1'b0);
		text_q.push_back({8'hff, 1'b0});
		push_string("&&", 1'b1);
		push_string("&g", 1'b1);
		directed_items = text_q.size();

		// random texts built from entity-shaped pieces
		while (text_q.size() < directed_items + RANDOM_ITEMS) begin
			text_bytes.delete();
			chunks = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 8);
			for (int i = 0; i < chunks; i++)
				add_chunk();
			for (int i = 0; i < text_bytes.size(); i++)
				text_q.push_back({text_bytes[i], i == text_bytes.size() - 1});
		end
		total_items = text_q.size();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted != total_items)
			@(posedge clk);
		while (decoded_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("** xml_entity_decoder_unit: PASSED **");
		else
			$display("** xml_entity_decoder_unit: FAILED **");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/xed_pkg.sv
rtl/xed_front.sv
rtl/xed_queue.sv
rtl/xed_back.sv
rtl/xml_entity_decoder_unit.sv
verif/xml_entity_decoder_unit_tb.sv
